[hw/rtl/sfcc_pkg.sv]
package sfcc_pkg;

  localparam logic [7:0]  SyncValue   = 8'hAA;
  localparam logic [15:0] CrcInit     = 16'hFFFF;
  localparam logic [15:0] CrcPoly     = 16'h1021;
  localparam logic [15:0] HeaderBytes = 16'd4;
  localparam logic [15:0] MinSize     = 16'd6;

  typedef struct packed {
    logic        crc_ok;
    logic        sync_ok;
    logic [7:0]  frame_type;
    logic [15:0] frame_size;
    logic [15:0] computed_crc;
    logic [15:0] received_crc;
    logic        size_error;
  } result_t;

  // One byte of CRC-16/CCITT-FALSE, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[hw/rtl/sfcc_if.sv]
interface sfcc_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source(output valid, output data_byte, output frame_start, input ready);
  modport sink(input valid, input data_byte, input frame_start, output ready);
endinterface

interface sfcc_result_if;
  logic        valid;
  logic        ready;
  logic        crc_ok;
  logic        sync_ok;
  logic [7:0]  frame_type;
  logic [15:0] frame_size;
  logic [15:0] computed_crc;
  logic [15:0] received_crc;
  logic        size_error;

  modport source(output valid, output crc_ok, output sync_ok, output frame_type,
                 output frame_size, output computed_crc, output received_crc,
                 output size_error, input ready);
  modport sink(input valid, input crc_ok, input sync_ok, input frame_type,
               input frame_size, input computed_crc, input received_crc,
               input size_error, output ready);
endinterface

[hw/rtl/synchrophasor_frame_crc_checker_core.sv]
// Frame CRC checker for byte-serial synchrophasor frames.
// The frame channel carries one byte per transfer together with frame_start,
// which marks byte 0 of a new frame. Bytes 2 and 3 give the total frame size,
// big-endian, including the trailing CRC. CRC-16/CCITT-FALSE runs over all
// bytes before the last two, which hold the received CRC.
// The result channel carries one transfer per completed frame: the CRC match,
// sync check, type byte, declared size, both CRC values and a size error flag.
// A declared size below six ends the frame after the header with size_error.
// A frame_start inside a frame drops the partial frame with no result.
// One byte per cycle unless the result stalls; the CRC update is combinational.
// Result valid follows the byte transfer that closes a frame: the input register
// captures the byte at the transfer edge and the result register then loads it
// once the result channel is not stalled.
// Synchronous reset empties both registers and returns the checker to idle.
// When the receiver stalls with a result pending, the input register holds and
// the frame channel takes at most one more byte, then drops ready until the
// result moves.
module synchrophasor_frame_crc_checker_core (
  input logic            clk,
  input logic            rst,
  sfcc_frame_if.sink     frame,
  sfcc_result_if.source  result
);

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_start;

  // Frame state.
  logic [15:0] running_crc;
  logic [15:0] byte_position;
  logic [15:0] declared_size;
  logic [7:0]  type_byte;
  logic        sync_seen_ok;
  logic [15:0] trailing_crc;
  logic        in_frame;

  // Result register.
  logic                 out_valid;
  sfcc_pkg::result_t    out_data;

  logic stall;
  logic s1_fire;

  assign stall       = out_valid && !result.ready;
  assign s1_fire     = s1_valid && !stall;
  assign frame.ready = !s1_valid || !stall;

  // Working values for the byte in the input register.
  logic        active;
  logic [15:0] pos;
  logic [15:0] crc_base;
  logic [15:0] dsz_base;
  logic [7:0]  type_base;
  logic        sync_base;
  logic [15:0] trail_base;
  logic        sync_next;
  logic [7:0]  type_next;
  logic [15:0] dsz_next;
  logic        use_crc;
  logic [15:0] crc_next;
  logic [15:0] trail_next;
  logic        emit_size;
  logic        emit_end;
  logic        emit;
  sfcc_pkg::result_t res_next;

  always_comb begin
    active     = s1_start || in_frame;
    pos        = s1_start ? 16'd0 : byte_position;
    crc_base   = s1_start ? sfcc_pkg::CrcInit : running_crc;
    dsz_base   = s1_start ? 16'd0 : declared_size;
    type_base  = s1_start ? 8'd0 : type_byte;
    sync_base  = s1_start ? 1'b0 : sync_seen_ok;
    trail_base = s1_start ? 16'd0 : trailing_crc;

    sync_next = (pos == 16'd0) ? (s1_byte == sfcc_pkg::SyncValue) : sync_base;
    type_next = (pos == 16'd1) ? s1_byte : type_base;
    if (pos == 16'd2) begin
      dsz_next = {s1_byte, 8'h00};
    end else if (pos == 16'd3) begin
      dsz_next = {dsz_base[15:8], s1_byte};
    end else begin
      dsz_next = dsz_base;
    end

    use_crc    = (pos < sfcc_pkg::HeaderBytes) ||
                 (({1'b0, pos} + 17'd2) < {1'b0, dsz_next});
    crc_next   = use_crc ? sfcc_pkg::crc_byte(crc_base, s1_byte) : crc_base;
    trail_next = use_crc ? trail_base : {trail_base[7:0], s1_byte};

    emit_size = (pos == sfcc_pkg::HeaderBytes - 16'd1) && (dsz_next < sfcc_pkg::MinSize);
    emit_end  = (pos >= sfcc_pkg::HeaderBytes) &&
                (({1'b0, pos} + 17'd1) == {1'b0, dsz_next});
    emit      = active && (emit_size || emit_end);

    res_next.sync_ok      = sync_next;
    res_next.frame_type   = type_next;
    res_next.frame_size   = dsz_next;
    res_next.computed_crc = crc_next;
    res_next.size_error   = emit_size;
    res_next.received_crc = emit_size ? 16'd0 : trail_next;
    res_next.crc_ok       = !emit_size && (crc_next == trail_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (frame.ready) begin
      s1_valid <= frame.valid;
    end
    if (frame.ready) begin
      s1_byte  <= frame.data_byte;
      s1_start <= frame.frame_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc   <= sfcc_pkg::CrcInit;
      byte_position <= 16'd0;
      declared_size <= 16'd0;
      type_byte     <= 8'd0;
      sync_seen_ok  <= 1'b0;
      trailing_crc  <= 16'd0;
      in_frame      <= 1'b0;
    end else if (s1_fire && active) begin
      running_crc   <= crc_next;
      declared_size <= dsz_next;
      type_byte     <= type_next;
      sync_seen_ok  <= sync_next;
      trailing_crc  <= trail_next;
      if (emit_size || emit_end) begin
        byte_position <= pos;
        in_frame      <= 1'b0;
      end else begin
        byte_position <= pos + 16'd1;
        in_frame      <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!stall) begin
      out_valid <= s1_valid && emit;
    end
    if (!stall && s1_valid && emit) begin
      out_data <= res_next;
    end
  end

  assign result.valid        = out_valid;
  assign result.crc_ok       = out_data.crc_ok;
  assign result.sync_ok      = out_data.sync_ok;
  assign result.frame_type   = out_data.frame_type;
  assign result.frame_size   = out_data.frame_size;
  assign result.computed_crc = out_data.computed_crc;
  assign result.received_crc = out_data.received_crc;
  assign result.size_error   = out_data.size_error;

endmodule

[test/synchrophasor_frame_crc_checker_core_tb.sv]
`timescale 1ns / 100ps

module synchrophasor_frame_crc_checker_core_tb;

  localparam int WatchdogLimit = 2000;
  localparam int RxHoldCycles  = 300;
  localparam int DrainCycles   = 8;
  localparam int MaxReported   = 10;
  localparam int WholeFrame    = 1 << 20;

  logic clk;
  logic rst;

  sfcc_frame_if  frame_ch ();
  sfcc_result_if result_ch ();

  synchrophasor_frame_crc_checker_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .frame  (frame_ch),
    .result (result_ch)
  );

  // Shadow copy of the checker state, advanced on every accepted byte of a frame.
  logic [15:0] crc_acc;
  logic [15:0] byte_pos;
  logic [15:0] size_decl;
  logic [7:0]  type_reg;
  logic        sync_match;
  logic [15:0] rx_crc;
  logic        frame_open;

  sfcc_pkg::result_t pending_reports[$];

  int  mismatches    = 0;
  int  useful_bytes  = 0;
  int  idle_run      = 0;
  int  src_idle_pct  = 35;
  int  sink_idle_pct = 48;
  bit  hold_req      = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [15:0] crc16_ccitt_step(input logic [15:0] acc,
                                                   input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int k = 7; k >= 0; k--) begin
      fb = r[15] ^ b[k];
      r = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ sfcc_pkg::CrcPoly;
      end
    end
    return r;
  endfunction

  // Returns 1 when the byte is consumed by a frame, 0 when it is dropped while idle.
  function automatic bit track_frame_byte(input logic [7:0] b, input logic s);
    sfcc_pkg::result_t rep;
    int unsigned       pos;
    if (s) begin
      crc_acc    = sfcc_pkg::CrcInit;
      byte_pos   = '0;
      size_decl  = '0;
      type_reg   = '0;
      sync_match = 1'b0;
      rx_crc     = '0;
      frame_open = 1'b1;
    end else if (!frame_open) begin
      return 1'b0;
    end
    pos = byte_pos;
    case (pos)
      0: sync_match = (b == sfcc_pkg::SyncValue);
      1: type_reg = b;
      2: size_decl = {b, 8'h00};
      3: size_decl[7:0] = b;
      default: ;
    endcase
    if (pos < sfcc_pkg::HeaderBytes || pos + 2 < size_decl) begin
      crc_acc = crc16_ccitt_step(crc_acc, b);
    end else begin
      rx_crc = {rx_crc[7:0], b};
    end
    rep.sync_ok      = sync_match;
    rep.frame_type   = type_reg;
    rep.frame_size   = size_decl;
    rep.computed_crc = crc_acc;
    if (pos == sfcc_pkg::HeaderBytes - 1 && size_decl < sfcc_pkg::MinSize) begin
      rep.crc_ok       = 1'b0;
      rep.received_crc = '0;
      rep.size_error   = 1'b1;
      pending_reports.push_back(rep);
      frame_open = 1'b0;
    end else if (pos >= sfcc_pkg::HeaderBytes && pos + 1 == size_decl) begin
      rep.crc_ok       = (crc_acc == rx_crc);
      rep.received_crc = rx_crc;
      rep.size_error   = 1'b0;
      pending_reports.push_back(rep);
      frame_open = 1'b0;
    end else begin
      byte_pos = byte_pos + 16'd1;
    end
    return 1'b1;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_byte(input logic [7:0] b, input logic s);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      frame_ch.valid <= 1'b0;
      @(negedge clk);
    end
    frame_ch.valid       <= 1'b1;
    frame_ch.data_byte   <= b;
    frame_ch.frame_start <= s;
    do @(posedge clk); while (!frame_ch.ready);
    if (track_frame_byte(b, s)) begin
      useful_bytes++;
    end
    @(negedge clk);
  endtask

  // Sends up to cut bytes of a frame; a good CRC is computed, a bad one is
  // the good one with some bits flipped.
  task automatic send_frame(input logic [7:0] sync_b, input logic [7:0] type_b,
                            input logic [15:0] size, input bit good, input int cut);
    int          sz;
    int          n;
    logic [15:0] run_crc;
    logic [15:0] tx_crc;
    logic [7:0]  b;
    sz = int'(size);
    n = (sz < int'(sfcc_pkg::MinSize)) ? int'(sfcc_pkg::HeaderBytes) : sz;
    if (cut < n) begin
      n = cut;
    end
    run_crc = sfcc_pkg::CrcInit;
    tx_crc = '0;
    for (int i = 0; i < n; i++) begin
      if (i == 0) begin
        b = sync_b;
      end else if (i == 1) begin
        b = type_b;
      end else if (i == 2) begin
        b = size[15:8];
      end else if (i == 3) begin
        b = size[7:0];
      end else if (i == sz - 2) begin
        tx_crc = good ? run_crc : run_crc ^ 16'($urandom_range(1, 65535));
        b = tx_crc[15:8];
      end else if (i == sz - 1) begin
        b = tx_crc[7:0];
      end else begin
        b = 8'($urandom_range(0, 255));
      end
      if (i < int'(sfcc_pkg::HeaderBytes) || i < sz - 2) begin
        run_crc = crc16_ccitt_step(run_crc, b);
      end
      send_byte(b, i == 0);
    end
  endtask

  task automatic wait_drained;
    frame_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic test_ignored_bytes;
    send_byte(8'hFF, 1'b0);
  endtask

  task automatic test_short_size;
    send_frame(sfcc_pkg::SyncValue, 8'h00, 16'h0000, 1'b1, WholeFrame);
    send_frame(8'h00, 8'hFF, 16'h0005, 1'b1, WholeFrame);
  endtask

  task automatic test_restart_mid_frame;
    send_frame(sfcc_pkg::SyncValue, 8'h12, 16'h0006, 1'b1, 2);
    send_frame(sfcc_pkg::SyncValue, 8'hFF, 16'h0006, 1'b1, WholeFrame);
  endtask

  task automatic test_bad_sync_and_crc;
    send_frame(8'h55, 8'h00, 16'h0006, 1'b0, WholeFrame);
  endtask

  task automatic test_random_frames(input int target);
    int          first;
    int          kind;
    logic [15:0] size;
    first = useful_bytes;
    while (useful_bytes - first < target) begin
      kind = $urandom_range(0, 99);
      size = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(25, 300))
                                          : 16'($urandom_range(6, 24));
      if (kind < 60) begin
        send_frame(sfcc_pkg::SyncValue, 8'($urandom_range(0, 255)), size, 1'b1,
                   WholeFrame);
      end else if (kind < 72) begin
        send_frame(sfcc_pkg::SyncValue, 8'($urandom_range(0, 255)), size, 1'b0,
                   WholeFrame);
      end else if (kind < 80) begin
        send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), size,
                   1'($urandom_range(0, 1)), WholeFrame);
      end else if (kind < 88) begin
        send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   16'($urandom_range(0, 5)), 1'b1, WholeFrame);
      end else if (kind < 95) begin
        send_frame(sfcc_pkg::SyncValue, 8'($urandom_range(0, 255)), size, 1'b1,
                   int'($urandom_range(1, size - 1)));
      end else begin
        // Stray bytes without a start flag: dropped when idle, absorbed after an abort.
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    end
  endtask

  // The receiver stalls for a long stretch while short frames keep coming,
  // so the result path backs up into the byte input.
  task automatic test_output_backpressure;
    hold_req = 1'b1;
    repeat (12) begin
      send_frame(sfcc_pkg::SyncValue, 8'($urandom_range(0, 255)), 16'h0006, 1'b1,
                 WholeFrame);
    end
    wait_drained();
  endtask

  // A frame whose declared size has a nonzero upper byte.
  task automatic test_long_frame;
    send_frame(sfcc_pkg::SyncValue, 8'h5A, 16'h0190, 1'b1, WholeFrame);
  endtask

  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (RxHoldCycles - 1) @(negedge clk);
      end else begin
        result_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    sfcc_pkg::result_t got;
    sfcc_pkg::result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = {result_ch.crc_ok, result_ch.sync_ok, result_ch.frame_type,
             result_ch.frame_size, result_ch.computed_crc, result_ch.received_crc,
             result_ch.size_error};
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported) begin
          $display("unexpected result: ok=%0b sync=%0b type=%02h size=%04h %s",
                   got.crc_ok, got.sync_ok, got.frame_type, got.frame_size,
                   $sformatf("crc=%04h rx=%04h serr=%0b",
                             got.computed_crc, got.received_crc, got.size_error));
        end
      end else begin
        want = pending_reports.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MaxReported) begin
            $display("mismatch expected: ok=%0b sync=%0b type=%02h size=%04h %s",
                     want.crc_ok, want.sync_ok, want.frame_type, want.frame_size,
                     $sformatf("crc=%04h rx=%04h serr=%0b",
                               want.computed_crc, want.received_crc, want.size_error));
            $display("         actual:   ok=%0b sync=%0b type=%02h size=%04h %s",
                     got.crc_ok, got.sync_ok, got.frame_type, got.frame_size,
                     $sformatf("crc=%04h rx=%04h serr=%0b",
                               got.computed_crc, got.received_crc, got.size_error));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready)) begin
        idle_run <= 0;
      end else begin
        idle_run <= idle_run + 1;
      end
      if (idle_run >= WatchdogLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    frame_ch.valid       = 1'b0;
    frame_ch.data_byte   = '0;
    frame_ch.frame_start = 1'b0;
    crc_acc    = sfcc_pkg::CrcInit;
    byte_pos   = '0;
    size_decl  = '0;
    type_reg   = '0;
    sync_match = 1'b0;
    rx_crc     = '0;
    frame_open = 1'b0;
    rst = 1'b1;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_ignored_bytes();
    test_short_size();
    test_restart_mid_frame();
    test_bad_sync_and_crc();
    test_random_frames(550);
    test_output_backpressure();

    src_idle_pct  = 48;
    sink_idle_pct = 35;
    test_random_frames(550);
    wait_drained();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_frames(350);
    test_long_frame();
    wait_drained();

    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/sfcc_pkg.sv
hw/rtl/sfcc_if.sv
hw/rtl/synchrophasor_frame_crc_checker_core.sv
test/synchrophasor_frame_crc_checker_core_tb.sv
